FILE: rtl/tkbt_pkg.sv
// Shared types and constants for the touch key baseline tracker.
// Holds the channel state, configuration, transaction and decision types.
// No dependencies.
package tkbt_pkg;

    localparam int CHANNELS     = 2;
    localparam int CHANNEL_BITS = 1;
    localparam int SAMPLE_BITS  = 10;
    localparam int COUNT_BITS   = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [SAMPLE_BITS-1:0] LEVEL_MAX = {SAMPLE_BITS{1'b1}};

    localparam logic [SAMPLE_BITS-1:0] PRESS_THRESHOLD_RST   = SAMPLE_BITS'(40);
    localparam logic [SAMPLE_BITS-1:0] RELEASE_THRESHOLD_RST = SAMPLE_BITS'(20);
    localparam logic [SAMPLE_BITS-1:0] CHANGE_THRESHOLD_RST  = SAMPLE_BITS'(20);
    localparam logic [COUNT_BITS-1:0]  SETTLE_LIMIT_RST      = COUNT_BITS'(20);

    typedef enum logic [1:0] {
        DEC_RELEASED = 2'd0,
        DEC_PRESSED  = 2'd1,
        DEC_HOLD     = 2'd2
    } decision_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PRESS_THRESHOLD   = 2'd0,
        CFG_RELEASE_THRESHOLD = 2'd1,
        CFG_CHANGE_THRESHOLD  = 2'd2,
        CFG_SETTLE_LIMIT      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] press_threshold;
        logic [SAMPLE_BITS-1:0] release_threshold;
        logic [SAMPLE_BITS-1:0] change_threshold;
        logic [COUNT_BITS-1:0]  settle_limit;
    } cfg_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0]  raw_sample;
        logic                    track;
    } item_t;

    typedef struct packed {
        logic [1:0]             decision;
        logic                   key_pressed;
        logic [SAMPLE_BITS-1:0] zero_level;
    } result_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] baseline;
        logic [SAMPLE_BITS-1:0] previous_level;
        logic [COUNT_BITS-1:0]  settle_count;
        logic                   pressed;
    } chan_state_t;

    localparam chan_state_t CHAN_STATE_RST = '{
        baseline:       LEVEL_MAX,
        previous_level: LEVEL_MAX,
        settle_count:   '0,
        pressed:        1'b0
    };

endpackage

FILE: rtl/tkbt_if.sv
// Valid/ready channel interfaces for the touch key baseline tracker.
// Depends on tkbt_pkg for field widths.
interface tkbt_in_if;
    logic                               valid;
    logic                               ready;
    logic [tkbt_pkg::CHANNEL_BITS-1:0]  channel;
    logic [tkbt_pkg::SAMPLE_BITS-1:0]   raw_sample;
    logic                               track;

    modport source (output valid, output channel, output raw_sample, output track,
                    input ready);
    modport sink   (input valid, input channel, input raw_sample, input track,
                    output ready);
endinterface

interface tkbt_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         decision;
    logic                               key_pressed;
    logic [tkbt_pkg::SAMPLE_BITS-1:0]   zero_level;

    modport source (output valid, output decision, output key_pressed, output zero_level,
                    input ready);
    modport sink   (input valid, input decision, input key_pressed, input zero_level,
                    output ready);
endinterface

FILE: rtl/tkbt_state.sv
// Per-channel state registers: baseline, previous level, settle count, key state.
// One combinational read port and one write port. Depends on tkbt_pkg.
module tkbt_state
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [tkbt_pkg::CHANNEL_BITS-1:0]  rd_channel,
    output tkbt_pkg::chan_state_t              rd_state,
    input  logic                               wr_en,
    input  logic [tkbt_pkg::CHANNEL_BITS-1:0]  wr_channel,
    input  tkbt_pkg::chan_state_t              wr_state
);

    tkbt_pkg::chan_state_t state_reg [tkbt_pkg::CHANNELS];
    tkbt_pkg::chan_state_t state_next [tkbt_pkg::CHANNELS];

    always_comb
    begin
        for (int i = 0; i < tkbt_pkg::CHANNELS; i++)
        begin
            state_next[i] = state_reg[i];
            if (wr_en && (int'(wr_channel) == i))
            begin
                state_next[i] = wr_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tkbt_pkg::CHANNELS; i++)
            begin
                state_reg[i] <= tkbt_pkg::CHAN_STATE_RST;
            end
        end
        else
        begin
            for (int i = 0; i < tkbt_pkg::CHANNELS; i++)
            begin
                state_reg[i] <= state_next[i];
            end
        end
    end

    assign rd_state = state_reg[rd_channel];

endmodule

FILE: rtl/tkbt_core.sv
// Combinational step: classifies one sample with hysteresis and applies the
// auto-zero rule to the channel state. Depends on tkbt_pkg.
module tkbt_core
(
    input  tkbt_pkg::cfg_t         cfg,
    input  tkbt_pkg::item_t        item,
    input  tkbt_pkg::chan_state_t  cur_state,
    output tkbt_pkg::chan_state_t  new_state,
    output logic                   state_wr,
    output tkbt_pkg::result_t      result
);

    logic [tkbt_pkg::SAMPLE_BITS-1:0] level;
    logic [tkbt_pkg::SAMPLE_BITS-1:0] rise;
    logic [tkbt_pkg::SAMPLE_BITS-1:0] diff;
    logic [tkbt_pkg::COUNT_BITS-1:0]  count_inc;
    logic                             fell;
    logic                             in_range;
    tkbt_pkg::decision_t              dec;

    always_comb
    begin
        in_range = (int'(item.channel) < tkbt_pkg::CHANNELS);

        // Touching lowers the raw reading, so the inverted level rises.
        level = tkbt_pkg::LEVEL_MAX - item.raw_sample;
        rise  = level - cur_state.baseline;

        if (level < cur_state.baseline)
        begin
            dec = tkbt_pkg::DEC_RELEASED;
        end
        else if (rise >= cfg.press_threshold)
        begin
            dec = tkbt_pkg::DEC_PRESSED;
        end
        else if (rise <= cfg.release_threshold)
        begin
            dec = tkbt_pkg::DEC_RELEASED;
        end
        else
        begin
            dec = tkbt_pkg::DEC_HOLD;
        end

        new_state = cur_state;
        case (dec)
            tkbt_pkg::DEC_RELEASED: new_state.pressed = 1'b0;
            tkbt_pkg::DEC_PRESSED:  new_state.pressed = 1'b1;
            default:                new_state.pressed = cur_state.pressed;
        endcase

        fell      = level < cur_state.previous_level;
        diff      = fell ? (cur_state.previous_level - level)
                         : (level - cur_state.previous_level);
        count_inc = cur_state.settle_count + tkbt_pkg::COUNT_BITS'(1);

        if (item.track)
        begin
            if (diff >= cfg.change_threshold)
            begin
                new_state.settle_count = '0;
                if (fell)
                begin
                    new_state.baseline = level;
                end
            end
            else if (count_inc >= cfg.settle_limit)
            begin
                new_state.settle_count = '0;
                new_state.baseline     = cur_state.previous_level;
            end
            else
            begin
                new_state.settle_count = count_inc;
            end
            new_state.previous_level = level;
        end

        state_wr = in_range;
        if (in_range)
        begin
            result.decision    = dec;
            result.key_pressed = new_state.pressed;
            result.zero_level  = new_state.baseline;
        end
        else
        begin
            result.decision    = tkbt_pkg::DEC_HOLD;
            result.key_pressed = 1'b0;
            result.zero_level  = '0;
        end
    end

endmodule

FILE: rtl/touch_key_baseline_tracker_unit.sv
// Top level of the touch key baseline tracker: input register, step logic,
// result register and configuration registers.
// Depends on tkbt_pkg, tkbt_if, tkbt_state and tkbt_core.
//
//   Port       Direction  Payload                                  Handshake
//   in_ch      sink       channel, raw_sample, track               valid/ready
//   out_ch     source     decision, key_pressed, zero_level        valid/ready
//   cfg_*      sink       cfg_index (2 bits), cfg_wdata (10 bits)  cfg_we only
//
// Each transaction passes through the input register and then lands in the
// result register; one transaction is taken per cycle while the output is not
// stalled. The channel state is read and written back in the cycle that moves the
// input register into the result register, so a transaction on the same channel
// right behind it sees the updated state. Reset (rst_n, asynchronous) sets the
// thresholds to their defaults and every channel baseline and previous level to
// full scale. A stalled output holds the result register; the input register
// still takes one more transaction, after which in_ch.ready drops.
module touch_key_baseline_tracker_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tkbt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tkbt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    tkbt_in_if.sink                             in_ch,
    tkbt_out_if.source                          out_ch
);

    // Configuration registers.
    tkbt_pkg::cfg_t cfg_reg;
    tkbt_pkg::cfg_t cfg_next;

    // Input stage and result stage.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    tkbt_pkg::item_t       s1_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tkbt_pkg::result_t     out_result_reg;

    logic                  out_free;
    logic                  s1_adv;
    logic                  in_accept;

    tkbt_pkg::chan_state_t cur_state;
    tkbt_pkg::chan_state_t new_state;
    logic                  state_wr;
    tkbt_pkg::result_t     step_result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tkbt_pkg::cfg_index_t'(cfg_index))
                tkbt_pkg::CFG_PRESS_THRESHOLD:
                    cfg_next.press_threshold = cfg_wdata;
                tkbt_pkg::CFG_RELEASE_THRESHOLD:
                    cfg_next.release_threshold = cfg_wdata;
                tkbt_pkg::CFG_CHANGE_THRESHOLD:
                    cfg_next.change_threshold = cfg_wdata;
                tkbt_pkg::CFG_SETTLE_LIMIT:
                    cfg_next.settle_limit = cfg_wdata[tkbt_pkg::COUNT_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_threshold   <= tkbt_pkg::PRESS_THRESHOLD_RST;
            cfg_reg.release_threshold <= tkbt_pkg::RELEASE_THRESHOLD_RST;
            cfg_reg.change_threshold  <= tkbt_pkg::CHANGE_THRESHOLD_RST;
            cfg_reg.settle_limit      <= tkbt_pkg::SETTLE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The result register is free when empty or when its transaction leaves
    // this cycle; the input register moves forward whenever it is free.
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.channel    <= in_ch.channel;
            s1_item_reg.raw_sample <= in_ch.raw_sample;
            s1_item_reg.track      <= in_ch.track;
        end
        if (s1_adv)
        begin
            out_result_reg <= step_result;
        end
    end

    tkbt_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_channel (s1_item_reg.channel),
        .rd_state   (cur_state),
        .wr_en      (s1_adv && state_wr),
        .wr_channel (s1_item_reg.channel),
        .wr_state   (new_state)
    );

    tkbt_core u_core
    (
        .cfg       (cfg_reg),
        .item      (s1_item_reg),
        .cur_state (cur_state),
        .new_state (new_state),
        .state_wr  (state_wr),
        .result    (step_result)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.decision    = out_result_reg.decision;
    assign out_ch.key_pressed = out_result_reg.key_pressed;
    assign out_ch.zero_level  = out_result_reg.zero_level;

endmodule
